// ----- design/heq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer package
// Shared sizes, codes, the sequencer state type and address helpers.
// ----------------------------------------------------------------------------
package heq_pkg;

  localparam int LEVELS       = 256;
  localparam int COUNT_BITS   = 25;
  localparam int MAX_CHANNELS = 3;

  localparam int SAMPLE_W  = 8;
  localparam int ACTION_W  = 2;
  localparam int CHCNT_W   = 2;
  localparam int TGT_W     = 9;
  localparam int AREA_W    = 25;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = AREA_W;

  localparam int LVL_W   = $clog2(LEVELS);
  localparam int CH_W    = $clog2(MAX_CHANNELS + 1);
  localparam int DEPTH   = MAX_CHANNELS * LEVELS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CUM_W   = COUNT_BITS + LVL_W;
  localparam int REM_W   = CUM_W + TGT_W;
  localparam int QUO_W   = 8;
  localparam int STEP_W  = $clog2(QUO_W + 1);
  localparam int MAP_W   = QUO_W + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_COUNT = 2'd1,
    ACT_BUILD = 2'd2,
    ACT_MAP   = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNELS = 2'd0,
    REG_TARGET   = 2'd1,
    REG_AREA     = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_CNT_RD,
    S_CNT_WR,
    S_MAP_RD,
    S_MAP_USE,
    S_MAP_DONE,
    S_BLD_RD,
    S_BLD_ACC,
    S_BLD_MUL,
    S_BLD_DIV,
    S_BLD_WR
  } state_e;

  // Clamp a sample to the highest level.
  function automatic logic [LVL_W-1:0] level_of(input logic [SAMPLE_W-1:0] s);
    logic [LVL_W-1:0] r;
    if ({1'b0, s} >= (SAMPLE_W+1)'(LEVELS)) begin
      r = LVL_W'(LEVELS - 1);
    end else begin
      r = LVL_W'(s);
    end
    return r;
  endfunction

  // Memory slot of one channel's level.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CH_W-1:0] ch,
                                                  input logic [LVL_W-1:0] lvl);
    return ADDR_W'(ch) * ADDR_W'(LEVELS) + ADDR_W'(lvl);
  endfunction

endpackage

// ----- design/heq_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer input channel
// One pixel item: action code and three channel samples.
// ----------------------------------------------------------------------------
interface heq_in_if import heq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SAMPLE_W-1:0] sample_a;
  logic [SAMPLE_W-1:0] sample_b;
  logic [SAMPLE_W-1:0] sample_c;

  modport source (output valid, action, sample_a, sample_b, sample_c, input ready);
  modport sink   (input valid, action, sample_a, sample_b, sample_c, output ready);
endinterface

// ----- design/heq_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer output channel
// One mapped pixel item with its clip flag.
// ----------------------------------------------------------------------------
interface heq_out_if import heq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] mapped_a;
  logic [SAMPLE_W-1:0] mapped_b;
  logic [SAMPLE_W-1:0] mapped_c;
  logic                clipped;

  modport source (output valid, mapped_a, mapped_b, mapped_c, clipped, input ready);
  modport sink   (input valid, mapped_a, mapped_b, mapped_c, clipped, output ready);
endinterface

// ----- design/heq_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer configuration channel
// Register write item: register index and write data.
// ----------------------------------------------------------------------------
interface heq_cfg_if import heq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/heq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module heq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/histogram_equalizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer core
// Per-channel histogram counting, map build by iterative division, and
// pixel mapping, all sequenced over two RAMs with one write and one read port each.
// ----------------------------------------------------------------------------
// One item at a time. A count item reads and writes its count slot once per
// active channel, and a map item reads one map entry per active channel.
// A clear item writes zero to all 768 count entries, one per cycle. A build
// item divides at each of the 768 slots, all channels and levels, using the
// shared compare/subtract unit of the divider.
// Reset: control and configuration registers return to their defaults and a
// clearing pass of all 768 count entries runs before the first item is taken.
module histogram_equalizer_core import heq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  heq_cfg_if.sink   cfg_i,
  heq_in_if.sink    in_i,
  heq_out_if.source out_o
);

  state_e state_q, state_d;

  logic [CHCNT_W-1:0] chcnt_q;
  logic [TGT_W-1:0]   tgt_q;
  logic [AREA_W-1:0]  area_q;

  logic [ADDR_W-1:0] clr_addr_q;
  logic [CH_W-1:0]   ch_q;
  logic [LVL_W-1:0]  lvl_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;

  logic [SAMPLE_W-1:0] smp_q [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] mres_q [MAX_CHANNELS];
  logic                mclip_q;
  logic [CUM_W-1:0]    cum_q;
  logic [REM_W-1:0]    rem_q;
  logic [QUO_W-1:0]    quo_q;
  logic                bclip_q;
  logic [SAMPLE_W-1:0] res_q [MAX_CHANNELS];
  logic                res_clip_q;

  logic                  cnt_we, map_we;
  logic [ADDR_W-1:0]     cnt_waddr, cur_addr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic [MAP_W-1:0]      map_wdata, map_rdata;

  logic              in_acc, out_free, last_ch, last_lvl;
  logic [CH_W-1:0]   n_act;
  logic [LVL_W-1:0]  lvl_cur;
  logic [REM_W-1:0]  divisor;
  logic              ge;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Active channels, with zero taken as one and large values clamped.
  always_comb begin
    if (chcnt_q == '0) begin
      n_act = CH_W'(1);
    end else if (CH_W'(chcnt_q) > CH_W'(MAX_CHANNELS)) begin
      n_act = CH_W'(MAX_CHANNELS);
    end else begin
      n_act = CH_W'(chcnt_q);
    end
  end

  assign last_ch  = (ch_q == n_act - CH_W'(1));
  assign last_lvl = (lvl_q == LVL_W'(LEVELS - 1));

  // Current slot: a pixel's level for count and map, the level walk for build.
  assign lvl_cur  = (state_q inside {S_BLD_RD, S_BLD_WR}) ? lvl_q : level_of(smp_q[ch_q]);
  assign cur_addr = slot_addr(ch_q, lvl_cur);

  // Shared compare/subtract unit: area shifted by the current quotient bit.
  assign divisor = REM_W'(area_q) << (STEP_W'(QUO_W) - step_q);
  assign ge      = (rem_q >= divisor);

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chcnt_q <= CHCNT_W'(1);
      tgt_q   <= TGT_W'(256);
      area_q  <= AREA_W'(65536);
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_CHANNELS: chcnt_q <= cfg_i.data[CHCNT_W-1:0];
        REG_TARGET:   tgt_q   <= cfg_i.data[TGT_W-1:0];
        REG_AREA:     area_q  <= cfg_i.data[AREA_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR: begin
        if (clr_addr_q == ADDR_W'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_i.valid) begin
          case (action_e'(in_i.action))
            ACT_CLEAR: state_d = S_CLR;
            ACT_COUNT: state_d = S_CNT_RD;
            ACT_BUILD: state_d = S_BLD_RD;
            ACT_MAP:   state_d = S_MAP_RD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_CNT_RD:   state_d = S_CNT_WR;
      S_CNT_WR:   state_d = last_ch ? S_IDLE : S_CNT_RD;
      S_MAP_RD:   state_d = S_MAP_USE;
      S_MAP_USE:  state_d = last_ch ? S_MAP_DONE : S_MAP_RD;
      S_MAP_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      S_BLD_RD:   state_d = S_BLD_ACC;
      S_BLD_ACC:  state_d = S_BLD_MUL;
      S_BLD_MUL:  state_d = S_BLD_DIV;
      S_BLD_DIV: begin
        if ((step_q == '0 && ge) || step_q == STEP_W'(QUO_W)) state_d = S_BLD_WR;
      end
      S_BLD_WR: begin
        if (last_lvl && ch_q == CH_W'(MAX_CHANNELS - 1)) state_d = S_IDLE;
        else state_d = S_BLD_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory controls and handshake outputs.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = cur_addr;
    cnt_wdata = '0;
    map_we    = 1'b0;
    map_wdata = bclip_q ? {1'b1, {QUO_W{1'b1}}} : {1'b0, quo_q};
    in_i.ready = (state_q == S_IDLE);
    case (state_q)
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr_q;
      end
      S_CNT_WR: begin
        cnt_we    = 1'b1;
        cnt_wdata = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);
      end
      S_BLD_WR: map_we = 1'b1;
      default: ;
    endcase
  end

  heq_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cur_addr),
    .rdata_o (cnt_rdata)
  );

  heq_ram #(.WIDTH(MAP_W), .DEPTH(DEPTH)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (cur_addr),
    .wdata_i (map_wdata),
    .raddr_i (cur_addr),
    .rdata_o (map_rdata)
  );

  // Sequencer control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_addr_q  <= '0;
      ch_q        <= '0;
      lvl_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        clr_addr_q <= '0;
        ch_q       <= '0;
        lvl_q      <= '0;
      end
      case (state_q)
        S_CLR:     clr_addr_q <= clr_addr_q + ADDR_W'(1);
        S_CNT_WR:  if (!last_ch) ch_q <= ch_q + CH_W'(1);
        S_MAP_USE: if (!last_ch) ch_q <= ch_q + CH_W'(1);
        S_BLD_MUL: step_q <= '0;
        S_BLD_DIV: step_q <= step_q + STEP_W'(1);
        S_BLD_WR: begin
          lvl_q <= last_lvl ? '0 : lvl_q + LVL_W'(1);
          if (last_lvl) begin
            ch_q <= (ch_q == CH_W'(MAX_CHANNELS - 1)) ? '0 : ch_q + CH_W'(1);
          end
        end
        default: ;
      endcase
      // The result register empties on take and loads from a finished map.
      if (state_q == S_MAP_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q[0] <= in_i.sample_a;
      smp_q[1] <= in_i.sample_b;
      smp_q[2] <= in_i.sample_c;
      for (int i = 0; i < MAX_CHANNELS; i++) mres_q[i] <= '0;
      mclip_q <= 1'b0;
      cum_q   <= '0;
    end
    case (state_q)
      S_MAP_USE: begin
        mres_q[ch_q] <= map_rdata[QUO_W-1:0];
        mclip_q      <= mclip_q | map_rdata[QUO_W];
      end
      S_BLD_ACC: cum_q <= cum_q + CUM_W'(cnt_rdata);
      S_BLD_MUL: begin
        rem_q   <= REM_W'(cum_q) * REM_W'(tgt_q);
        quo_q   <= '0;
        bclip_q <= 1'b0;
      end
      S_BLD_DIV: begin
        // The first step tests the quotient against its top, then one bit a step.
        if (step_q == '0) begin
          bclip_q <= ge;
        end else begin
          quo_q <= {quo_q[QUO_W-2:0], ge};
          if (ge) rem_q <= rem_q - divisor;
        end
      end
      S_BLD_WR: if (last_lvl) cum_q <= '0;
      default: ;
    endcase
    if (state_q == S_MAP_DONE && out_free) begin
      res_q      <= mres_q;
      res_clip_q <= mclip_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.mapped_a = res_q[0];
  assign out_o.mapped_b = res_q[1];
  assign out_o.mapped_c = res_q[2];
  assign out_o.clipped  = res_clip_q;

  // A saturated map entry always carries the full-scale value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_we && map_wdata[QUO_W] |-> map_wdata[QUO_W-1:0] == '1)
    else $error("clipped map entry without full-scale value");

  // The division never runs past its last quotient bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BLD_DIV |-> step_q <= STEP_W'(QUO_W))
    else $error("divider step count overrun");

  // A clear item starts its pass at the first slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.action == ACT_CLEAR |=> state_q == S_CLR && clr_addr_q == '0)
    else $error("clear pass did not start at slot zero");

endmodule
